### rtl/core/svc_pkg.sv
// ----------------------------------------------------------------------------
// svc_pkg
// Shared widths, register codes and inter-stage types for the segment cull.
// ----------------------------------------------------------------------------
package svc_pkg;

	localparam int COORD_W  = 16;  // endpoint coordinate width, two's complement
	localparam int DIM_W    = 13;  // screen width/height register width
	localparam int MARGIN_W = 12;  // endpoint test widening
	localparam int CFG_IDX_W = 1;

	localparam int DIFF_W = COORD_W + 1;  // segment vector component
	localparam int OFS_W  = COORD_W + 2;  // screen corner minus endpoint
	localparam int DIMS_W = DIM_W + 1;    // screen dimension as signed value
	localparam int EP_W   = ((COORD_W > DIM_W + 1) ? COORD_W : DIM_W + 1) + 2;
	localparam int WIDE_W = ((2 * COORD_W > OFS_W + DIMS_W) ? 2 * COORD_W
		: OFS_W + DIMS_W) + 4;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} screen_t;

	// Products feeding the edge crossing tests against top, right, bottom and left
	typedef struct packed {
		logic signed [WIDE_W-1:0] wry;   // w * ry
		logic signed [WIDE_W-1:0] hrx;   // h * rx
		logic signed [WIDE_W-1:0] t_top; // ay * w
		logic signed [WIDE_W-1:0] t_rgt; // (w - ax) * h
		logic signed [WIDE_W-1:0] t_bot; // (h - ay) * w
		logic signed [WIDE_W-1:0] t_lft; // ax * h
		logic signed [WIDE_W-1:0] axby;
		logic signed [WIDE_W-1:0] aybx;
	} products_t;

endpackage

### rtl/core/svc_cfg_regs.sv
// ----------------------------------------------------------------------------
// svc_cfg_regs
// Screen size registers behind a plain write port.
// ----------------------------------------------------------------------------
module svc_cfg_regs
	import svc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	output screen_t              screen
);

	screen_t screen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_q.width  <= DIM_W'(1920);
			screen_q.height <= DIM_W'(1080);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_WIDTH:  screen_q.width  <= cfg_data;
				REG_HEIGHT: screen_q.height <= cfg_data;
				default: ;
			endcase
		end
	end

	assign screen = screen_q;

endmodule

### rtl/core/svc_products.sv
// ----------------------------------------------------------------------------
// svc_products
// First compute stage: edge products and the widened-rectangle endpoint test.
// ----------------------------------------------------------------------------
module svc_products
	import svc_pkg::*;
(
	input  logic signed [COORD_W-1:0] ax,
	input  logic signed [COORD_W-1:0] ay,
	input  logic signed [COORD_W-1:0] bx,
	input  logic signed [COORD_W-1:0] by,
	input  logic [MARGIN_W-1:0]       margin,
	input  screen_t                   screen,
	output products_t                 prod,
	output logic                      vis
);

	logic signed [DIFF_W-1:0] rx, ry;
	logic signed [DIMS_W-1:0] ws, hs;
	logic signed [OFS_W-1:0]  wx, hy;

	logic signed [DIFF_W+DIMS_W-1:0]  wry_p, hrx_p;
	logic signed [COORD_W+DIMS_W-1:0] ayw_p, axh_p;
	logic signed [OFS_W+DIMS_W-1:0]   wxh_p, hyw_p;
	logic signed [2*COORD_W-1:0]      axby_p, aybx_p;

	logic signed [EP_W-1:0] m_e, w_hi, h_hi;

	assign ws = {1'b0, screen.width};
	assign hs = {1'b0, screen.height};
	assign rx = DIFF_W'(bx) - DIFF_W'(ax);
	assign ry = DIFF_W'(by) - DIFF_W'(ay);
	assign wx = OFS_W'(ws) - OFS_W'(ax);
	assign hy = OFS_W'(hs) - OFS_W'(ay);

	assign wry_p  = ry * ws;
	assign hrx_p  = rx * hs;
	assign ayw_p  = ay * ws;
	assign axh_p  = ax * hs;
	assign wxh_p  = wx * hs;
	assign hyw_p  = hy * ws;
	assign axby_p = ax * by;
	assign aybx_p = ay * bx;

	assign prod.wry   = WIDE_W'(wry_p);
	assign prod.hrx   = WIDE_W'(hrx_p);
	assign prod.t_top = WIDE_W'(ayw_p);
	assign prod.t_rgt = WIDE_W'(wxh_p);
	assign prod.t_bot = WIDE_W'(hyw_p);
	assign prod.t_lft = WIDE_W'(axh_p);
	assign prod.axby  = WIDE_W'(axby_p);
	assign prod.aybx  = WIDE_W'(aybx_p);

	// Widened rectangle bounds, inclusive
	assign m_e  = {{(EP_W-MARGIN_W){1'b0}}, margin};
	assign w_hi = EP_W'(ws) + m_e;
	assign h_hi = EP_W'(hs) + m_e;

	function automatic logic in_rect(input logic signed [COORD_W-1:0] x,
		input logic signed [COORD_W-1:0] y);
		logic signed [EP_W-1:0] xe, ye;
		xe = EP_W'(x);
		ye = EP_W'(y);
		return (xe >= -m_e) && (xe <= w_hi) && (ye >= -m_e) && (ye <= h_hi);
	endfunction

	assign vis = in_rect(ax, ay) || in_rect(bx, by);

endmodule

### rtl/core/svc_decide.sv
// ----------------------------------------------------------------------------
// svc_decide
// Second compute stage: parametric crossing tests against the top, right, bottom and left edges.
// ----------------------------------------------------------------------------
module svc_decide
	import svc_pkg::*;
(
	input  products_t prod,
	input  logic      vis,
	output logic      outside
);

	logic signed [WIDE_W-1:0] c;
	logic signed [WIDE_W-1:0] u_top, u_rgt, u_bot, u_lft;
	logic                     hit;

	// num/den in [0,1] for both ratios; parallel edge never crosses
	function automatic logic crosses(input logic signed [WIDE_W-1:0] den,
		input logic signed [WIDE_W-1:0] t, input logic signed [WIDE_W-1:0] u);
		logic pos_ok, neg_ok;
		pos_ok = (t >= 0) && (t <= den) && (u >= 0) && (u <= den);
		neg_ok = (t <= 0) && (t >= den) && (u <= 0) && (u >= den);
		if (den == '0)
			return 1'b0;
		else if (den > 0)
			return pos_ok;
		else
			return neg_ok;
	endfunction

	assign c     = prod.axby - prod.aybx;
	assign u_top = -c;
	assign u_rgt = prod.wry - c;
	assign u_bot = prod.wry - prod.hrx - c;
	assign u_lft = -prod.hrx - c;

	assign hit = crosses(-prod.wry, prod.t_top, u_top)
		|| crosses(prod.hrx, prod.t_rgt, u_rgt)
		|| crosses(prod.wry, prod.t_bot, u_bot)
		|| crosses(-prod.hrx, prod.t_lft, u_lft);

	assign outside = !(vis || hit);

endmodule

### rtl/core/segment_viewport_cull.sv
// ----------------------------------------------------------------------------
// segment_viewport_cull
// Trivial reject of a screen-space line segment against the visible screen.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with start_x, start_y, end_x, end_y
//   and margin. A transfer happens on a clock edge with in_valid high and
//   in_stall low. Each input transfer yields exactly one result transfer on
//   out_valid / out_stall carrying outside and endpoint_visible.
//   Path: from input transfer to out_valid through the input register,
//   product register and result register. Throughput: one segment per cycle
//   while out_stall is low; the three register stages each advance whenever
//   the stage after them is empty or is emptying in the same cycle.
//   Stall: while out_stall holds a pending result, the result register holds
//   and the stages behind it fill up; in_stall rises once all three hold data.
//   Configuration: cfg_wr_en writes the screen width (index 0) or the screen
//   height (index 1) from cfg_data; write only while no segment is in flight.
//   Reset: arst_n clears all stage valids; screen size returns to 1920x1080.
// ----------------------------------------------------------------------------
module segment_viewport_cull
	import svc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [DIM_W-1:0]          cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [COORD_W-1:0] start_x,
	input  logic signed [COORD_W-1:0] start_y,
	input  logic signed [COORD_W-1:0] end_x,
	input  logic signed [COORD_W-1:0] end_y,
	input  logic [MARGIN_W-1:0]       margin,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      outside,
	output logic                      endpoint_visible
);

	screen_t screen;

	// Stage 1: registered input
	logic                      valid_s1;
	logic signed [COORD_W-1:0] ax_s1, ay_s1, bx_s1, by_s1;
	logic [MARGIN_W-1:0]       margin_s1;

	// Stage 2: registered products
	logic      valid_s2;
	products_t prod_s2;
	logic      vis_s2;

	// Result register
	logic out_valid_q;
	logic outside_q;
	logic endpoint_visible_q;

	products_t prod_c;
	logic      vis_c;
	logic      outside_c;

	logic out_free, s2_free, s1_free;

	svc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.screen    (screen)
	);

	svc_products u_products (
		.ax     (ax_s1),
		.ay     (ay_s1),
		.bx     (bx_s1),
		.by     (by_s1),
		.margin (margin_s1),
		.screen (screen),
		.prod   (prod_c),
		.vis    (vis_c)
	);

	svc_decide u_decide (
		.prod    (prod_s2),
		.vis     (vis_s2),
		.outside (outside_c)
	);

	// A stage may take new data when empty or when its content moves on
	assign out_free = !out_valid_q || !out_stall;
	assign s2_free  = !valid_s2 || out_free;
	assign s1_free  = !valid_s1 || s2_free;
	assign in_stall = !s1_free;

	// Stage valids and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free)
				valid_s1 <= in_valid;
			if (s2_free)
				valid_s2 <= valid_s1;
			if (out_free)
				out_valid_q <= valid_s2;
		end
	end

	// Payload: load only when a valid item moves into the stage
	always_ff @(posedge clk) begin
		if (s1_free && in_valid) begin
			ax_s1     <= start_x;
			ay_s1     <= start_y;
			bx_s1     <= end_x;
			by_s1     <= end_y;
			margin_s1 <= margin;
		end
		if (s2_free && valid_s1) begin
			prod_s2 <= prod_c;
			vis_s2  <= vis_c;
		end
		if (out_free && valid_s2) begin
			outside_q          <= outside_c;
			endpoint_visible_q <= vis_s2;
		end
	end

	assign out_valid        = out_valid_q;
	assign outside          = outside_q;
	assign endpoint_visible = endpoint_visible_q;

endmodule

### rtl/core/svc_checker.sv
// ----------------------------------------------------------------------------
// svc_checker
// Port-level assertions for segment_viewport_cull, bound to the top level.
// ----------------------------------------------------------------------------
module svc_checker
	import svc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic outside,
	input logic endpoint_visible
);

	logic in_xfer;
	assign in_xfer = in_valid && !in_stall;

	// Hold a stalled result unchanged
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(outside)
			&& $stable(endpoint_visible)))
	else $error("stalled result changed or dropped");

	// A visible endpoint always keeps the segment
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && endpoint_visible) |-> !outside)
	else $error("segment culled with a visible endpoint");

	// Deliver a result after an input transfer when the output does not stall meanwhile
	assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer ##1 !out_stall ##1 !out_stall |=> out_valid)
	else $error("result missing after pipeline latency");

	// Drain to empty when no input transfers and the output never stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		(!in_xfer && !out_stall) ##1 (!in_xfer && !out_stall)
			##1 (!in_xfer && !out_stall) |=> !out_valid)
	else $error("result appeared without an input transfer");

endmodule

bind segment_viewport_cull svc_checker u_svc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.outside          (outside),
	.endpoint_visible (endpoint_visible)
);

### tb/sv/segment_viewport_cull_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_viewport_cull_tb
// Self-checking bench for the segment viewport trivial reject. A directed
// table of corner cases runs first, then random segments across several
// screen sizes, zero and full-range sizes among them. Each accepted segment
// is scored by a local cull predictor, or by its table verdict for typed
// directed rows, and each result transfer is checked in order against it.
// ----------------------------------------------------------------------------
module segment_viewport_cull_tb;
	import svc_pkg::*;

	localparam int CLK_HIGH         = 6;
	localparam int CLK_LOW          = 6;
	localparam int RESET_CYCLES     = 12;
	localparam int RANDOM_PER_PHASE = 100;
	localparam int N_PHASES         = 8;
	localparam int HOLD_OFF_CYCLES  = 40;
	localparam int DRAIN_CYCLES     = 8;
	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int N_DIRECTED       = 22;

	typedef struct packed {
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
		logic signed [COORD_W-1:0] ex;
		logic signed [COORD_W-1:0] ey;
		logic [MARGIN_W-1:0]       mg;
	} segment_t;

	typedef struct packed {
		logic outside;
		logic visible;
	} verdict_t;

	// typed = 1: verdict below is the expected result; otherwise predicted
	typedef struct packed {
		segment_t seg;
		logic     typed;
		verdict_t verdict;
	} seg_row_t;

	// All rows run with the reset screen size of 1920 x 1080
	localparam seg_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		// origin corner, then far corner, both visible
		'{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 12'd0}, 1'b1, '{1'b0, 1'b1}},
		'{'{16'sd1920, 16'sd1080, 16'sd1920, 16'sd1080, 12'd0}, 1'b1, '{1'b0, 1'b1}},
		// single points far away: zero-length segment never crosses
		'{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 12'd0}, 1'b1,
			'{1'b1, 1'b0}},
		'{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 12'd4095}, 1'b1,
			'{1'b1, 1'b0}},
		// widened bounds are inclusive at full margin
		'{'{-16'sd4095, -16'sd4095, -16'sd4095, -16'sd4095, 12'd4095}, 1'b1,
			'{1'b0, 1'b1}},
		'{'{16'sd6015, 16'sd5175, 16'sd6015, 16'sd5175, 12'd4095}, 1'b1, '{1'b0, 1'b1}},
		'{'{16'sd6016, 16'sd0, 16'sd6016, 16'sd0, 12'd4095}, 1'b1, '{1'b1, 1'b0}},
		'{'{-16'sd1, -16'sd1, -16'sd1, -16'sd1, 12'd0}, 1'b1, '{1'b1, 1'b0}},
		// horizontal through the screen
		'{'{-16'sd5000, 16'sd500, 16'sd5000, 16'sd500, 12'd0}, 1'b0, '{1'b0, 1'b0}},
		// collinear with the top edge, short of it and then past the corner
		'{'{-16'sd100, 16'sd0, -16'sd50, 16'sd0, 12'd0}, 1'b0, '{1'b0, 1'b0}},
		'{'{-16'sd100, 16'sd0, 16'sd3000, 16'sd0, 12'd0}, 1'b0, '{1'b0, 1'b0}},
		// touching the origin corner exactly
		'{'{-16'sd10, 16'sd10, 16'sd10, -16'sd10, 12'd0}, 1'b0, '{1'b0, 1'b0}},
		// parallel to the top edge, one row above it
		'{'{-16'sd100, -16'sd1, 16'sd3000, -16'sd1, 12'd0}, 1'b0, '{1'b0, 1'b0}},
		// opposite coordinate extremes
		'{'{16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 12'd0}, 1'b0,
			'{1'b0, 1'b0}},
		'{'{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 12'd0}, 1'b0,
			'{1'b0, 1'b0}},
		// just past the right edge, heading away
		'{'{16'sd1921, 16'sd540, 16'sd32767, 16'sd540, 12'd0}, 1'b0, '{1'b0, 1'b0}},
		'{'{16'sd1921, 16'sd540, 16'sd1921, 16'sd540, 12'd1}, 1'b0, '{1'b0, 1'b0}},
		// vertical through the screen, then a row above the top edge and a diagonal
		'{'{16'sd960, -16'sd10, 16'sd960, 16'sd2000, 12'd0}, 1'b0, '{1'b0, 1'b0}},
		'{'{-16'sd5, -16'sd5, 16'sd2000, -16'sd5, 12'd4}, 1'b0, '{1'b0, 1'b0}},
		'{'{16'sd2000, -16'sd100, -16'sd100, 16'sd2000, 12'd0}, 1'b0, '{1'b0, 1'b0}},
		// collinear with the right edge, touching the ends of top and bottom; then a far-left vertical
		'{'{16'sd1920, -16'sd100, 16'sd1920, 16'sd2000, 12'd0}, 1'b0, '{1'b0, 1'b0}},
		'{'{-16'sd32768, 16'sd0, -16'sd32768, 16'sd32767, 12'd4095}, 1'b0,
			'{1'b0, 1'b0}}
	};

	logic                      clk        = 1'b0;
	logic                      arst_n     = 1'b0;
	logic                      cfg_wr_en  = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index  = REG_WIDTH;
	logic [DIM_W-1:0]          cfg_data   = '0;
	logic                      in_valid   = 1'b0;
	logic                      in_stall;
	logic signed [COORD_W-1:0] start_x    = '0;
	logic signed [COORD_W-1:0] start_y    = '0;
	logic signed [COORD_W-1:0] end_x      = '0;
	logic signed [COORD_W-1:0] end_y      = '0;
	logic [MARGIN_W-1:0]       margin     = '0;
	logic                      out_valid;
	logic                      out_stall  = 1'b0;
	logic                      outside;
	logic                      endpoint_visible;

	// Local copy of the screen size registers
	int unsigned scr_width  = 1920;
	int unsigned scr_height = 1080;

	verdict_t cull_verdicts_q [$];
	verdict_t oldest_verdict;
	int       fail_count    = 0;
	int       idle_cycles   = 0;
	bit       hold_off_req  = 1'b0;
	int       burst_left    = 0;

	segment_viewport_cull u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.start_x          (start_x),
		.start_y          (start_y),
		.end_x            (end_x),
		.end_y            (end_y),
		.margin           (margin),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.outside          (outside),
		.endpoint_visible (endpoint_visible)
	);

	always begin
		#CLK_LOW  clk = 1'b1;
		#CLK_HIGH clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Cull predictor
	// ------------------------------------------------------------------------

	// num / den lies in [0, 1]; den is nonzero, so compare signs instead of dividing
	function automatic logic quotient_in_unit(longint num, longint den);
		if (den > 0) begin
			return (num >= 0) && (den - num >= 0);
		end
		return (num <= 0) && (den - num <= 0);
	endfunction

	// Segment a->b against screen edge c->e; parallel or collinear never crosses
	function automatic logic crosses_edge(longint ax, longint ay, longint bx, longint by,
			longint cx, longint cy, longint ex, longint ey);
		longint rx, ry, sx, sy, dx, dy, den;
		rx  = bx - ax;
		ry  = by - ay;
		sx  = ex - cx;
		sy  = ey - cy;
		dx  = cx - ax;
		dy  = cy - ay;
		den = rx * sy - ry * sx;
		if (den == 0) begin
			return 1'b0;
		end
		return quotient_in_unit(dx * sy - dy * sx, den)
			&& quotient_in_unit(dx * ry - dy * rx, den);
	endfunction

	function automatic logic in_widened_rect(longint x, longint y, longint w, longint h,
			longint m);
		return (x >= -m) && (x <= w + m) && (y >= -m) && (y <= h + m);
	endfunction

	function automatic verdict_t predict_cull(segment_t s);
		longint   ax, ay, bx, by, m, w, h;
		logic     hit;
		verdict_t v;
		ax  = s.sx;
		ay  = s.sy;
		bx  = s.ex;
		by  = s.ey;
		m   = longint'(s.mg);
		w   = longint'(scr_width);
		h   = longint'(scr_height);
		hit = 1'b0;
		v.visible = in_widened_rect(ax, ay, w, h, m) || in_widened_rect(bx, by, w, h, m);
		// edges are only examined when no endpoint shows
		if (!v.visible) begin
			hit = crosses_edge(ax, ay, bx, by, 0, 0, w, 0)
				|| crosses_edge(ax, ay, bx, by, w, 0, w, h)
				|| crosses_edge(ax, ay, bx, by, w, h, 0, h)
				|| crosses_edge(ax, ay, bx, by, 0, h, 0, 0);
		end
		v.outside = !(v.visible || hit);
		return v;
	endfunction

	// ------------------------------------------------------------------------
	// Random segment content
	// ------------------------------------------------------------------------

	// Mostly near the screen so both visibility and edge crossings vary
	function automatic logic signed [COORD_W-1:0] pick_coord(int unsigned dim);
		int c;
		case ($urandom_range(0, 9))
			0: begin
				c = int'($urandom_range(0, 65535)) - 32768;
			end
			1: begin
				c = $urandom_range(0, 1) ? 32767 : -32768;
			end
			2: begin
				c = $urandom_range(0, 1) ? 0 : int'(dim);
			end
			3: begin
				c = -int'($urandom_range(0, 4200));
			end
			default: begin
				c = int'($urandom_range(0, 3 * dim + 400)) - int'(dim) - 200;
			end
		endcase
		return c[COORD_W-1:0];
	endfunction

	function automatic segment_t random_segment();
		segment_t s;
		s.sx = pick_coord(scr_width);
		s.sy = pick_coord(scr_height);
		s.ex = pick_coord(scr_width);
		s.ey = pick_coord(scr_height);
		// bias toward axis-aligned segments so parallel edges come up often
		case ($urandom_range(0, 7))
			0: s.ey = s.sy;
			1: s.ex = s.sx;
			default: ;
		endcase
		case ($urandom_range(0, 19))
			0, 1, 2: s.mg = MARGIN_W'($urandom_range(0, 4095));
			3, 4, 5, 6, 7: s.mg = MARGIN_W'($urandom_range(0, 300));
			default: s.mg = MARGIN_W'($urandom_range(0, 15));
		endcase
		return s;
	endfunction

	// ------------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------------

	// Drive one segment at the falling edge, hold it until the transfer
	task automatic send_segment(segment_t s, logic typed, verdict_t typed_verdict);
		@(negedge clk);
		start_x  = s.sx;
		start_y  = s.sy;
		end_x    = s.ex;
		end_y    = s.ey;
		margin   = s.mg;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		cull_verdicts_q.insert(cull_verdicts_q.size(),
			typed ? typed_verdict : predict_cull(s));
	endtask

	// Bursts of random length; between bursts drop valid for a random gap, which may be zero
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(0, 29);
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Wait for the pipeline to empty, then write both screen registers
	task automatic program_screen(int unsigned w, int unsigned h);
		@(negedge clk);
		in_valid = 1'b0;
		while (cull_verdicts_q.size() != 0) @(posedge clk);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = REG_WIDTH;
		cfg_data  = w[DIM_W-1:0];
		@(negedge clk);
		cfg_index = REG_HEIGHT;
		cfg_data  = h[DIM_W-1:0];
		@(negedge clk);
		cfg_wr_en  = 1'b0;
		scr_width  = w;
		scr_height = h;
	endtask

	// ------------------------------------------------------------------------
	// Receiver side: its own stall pattern, plus a long hold-off on request
	// ------------------------------------------------------------------------
	initial begin
		int mode;
		int mode_left;
		int stall_run;
		int rx_cycle;
		mode      = 0;
		mode_left = 0;
		stall_run = 0;
		rx_cycle  = 0;
		forever begin
			@(negedge clk);
			rx_cycle++;
			if (hold_off_req) begin
				// hold off long enough for every stage to fill and stall the input
				out_stall = 1'b1;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
				hold_off_req = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(16, 96);
				end
				mode_left--;
				case (mode)
					0: out_stall = 1'b0;
					1: out_stall = 1'($urandom_range(0, 1));
					2: out_stall = (rx_cycle % 4 == 3);
					default: begin
						if (stall_run > 0) begin
							stall_run--;
							out_stall = 1'b1;
						end else if ($urandom_range(0, 5) == 0) begin
							stall_run = $urandom_range(1, 8);
							out_stall = 1'b1;
						end else begin
							out_stall = 1'b0;
						end
					end
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result checking and watchdog
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (cull_verdicts_q.size() == 0) begin
				$error("result transfer with no segment pending: outside %0b endpoint_visible %0b",
					outside, endpoint_visible);
				fail_count++;
			end else begin
				oldest_verdict = cull_verdicts_q.pop_front();
				if (outside !== oldest_verdict.outside) begin
					$error("outside: expected %0b, actual %0b", oldest_verdict.outside, outside);
					fail_count++;
				end
				if (endpoint_visible !== oldest_verdict.visible) begin
					$error("endpoint_visible: expected %0b, actual %0b",
						oldest_verdict.visible, endpoint_visible);
					fail_count++;
				end
			end
		end
		// count cycles in which neither channel moves a transfer
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int unsigned w;
		int unsigned h;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed corner cases at the reset screen size
		for (int i = 0; i < N_DIRECTED; i++) begin
			send_segment(DIRECTED_ROWS[i].seg, DIRECTED_ROWS[i].typed,
				DIRECTED_ROWS[i].verdict);
			pace_sender();
		end

		// Random phases; phase 0 keeps the reset size, the rest reprogram it
		for (int phase = 0; phase < N_PHASES; phase++) begin
			case (phase)
				1: begin w = 8191; h = 8191; end
				2: begin w = 1;    h = 1;    end
				3: begin w = 0;    h = 0;    end
				4: begin w = 0;    h = 8191; end
				5: begin w = 8191; h = 0;    end
				6: begin w = $urandom_range(1, 8191); h = $urandom_range(1, 8191); end
				7: begin w = $urandom_range(1, 255);  h = $urandom_range(1, 8191); end
				default: begin w = scr_width; h = scr_height; end
			endcase
			if (phase != 0) begin
				program_screen(w, h);
			end
			// long receiver hold-off while the sender keeps offering
			if (phase == 2 || phase == 6) begin
				hold_off_req = 1'b1;
			end
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				send_segment(random_segment(), 1'b0, '0);
				pace_sender();
			end
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (cull_verdicts_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
